/* rtl/core/internet_checksum_pseudo_header_defines.svh */
// Assertion helpers; expect clk and rst_n in scope.
`ifndef INTERNET_CHECKSUM_PSEUDO_HEADER_DEFINES_SVH
`define INTERNET_CHECKSUM_PSEUDO_HEADER_DEFINES_SVH

// Same-cycle implication.
`define ICS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checksum assertion failed");

// Next-cycle implication.
`define ICS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checksum assertion failed");

`endif

/* rtl/core/ics_pkg.sv */
`default_nettype none

package ics_pkg;

    localparam int unsigned WORD_W    = 16;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned PROTO_W   = 8;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 32;
    // four address halves plus protocol
    localparam int unsigned PSUM_W    = WORD_W + 3;
    // running sum + pseudo sum + length
    localparam int unsigned TOTAL_W   = WORD_W + 3;

    localparam logic [CFG_IDX_W-1:0] REG_USE_PSEUDO = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ADDR   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_ADDR   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL   = 8'd3;

    typedef struct packed {
        logic              use_pseudo;
        logic [PSUM_W-1:0] pseudo_sum;
    } ics_cfg_t;

    // Ones-complement add with end-around carry; never exceeds 16 bits.
    function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        logic [WORD_W:0] r;
        s = {1'b0, a} + {1'b0, b};
        r = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[WORD_W]};
        return r[WORD_W-1:0];
    endfunction

    // Full carry fold of a wide integer sum down to 16 bits.
    function automatic logic [WORD_W-1:0] fold(input logic [TOTAL_W-1:0] t);
        logic [WORD_W:0] f1;
        logic [WORD_W:0] f2;
        f1 = {1'b0, t[WORD_W-1:0]} + {{(WORD_W-2){1'b0}}, t[TOTAL_W-1:WORD_W]};
        f2 = {1'b0, f1[WORD_W-1:0]} + {{WORD_W{1'b0}}, f1[WORD_W]};
        return f2[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ics_cfg_regs.sv */
`default_nettype none

module ics_cfg_regs
    import ics_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output ics_cfg_t                   cfg
);

    logic               use_pseudo_reg;
    logic [ADDR_W-1:0]  src_addr_reg;
    logic [ADDR_W-1:0]  dst_addr_reg;
    logic [PROTO_W-1:0] protocol_reg;
    logic [PSUM_W-1:0]  pseudo_sum_reg;
    logic [PSUM_W-1:0]  pseudo_sum_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_pseudo_reg <= 1'b0;
            src_addr_reg   <= '0;
            dst_addr_reg   <= '0;
            protocol_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_USE_PSEUDO: use_pseudo_reg <= cfg_data[0];
                REG_SRC_ADDR:   src_addr_reg   <= cfg_data;
                REG_DST_ADDR:   dst_addr_reg   <= cfg_data;
                REG_PROTOCOL:   protocol_reg   <= cfg_data[PROTO_W-1:0];
                default:        ;
            endcase
        end
    end

    // plain integer sum; folded together with the payload sum later
    always_comb
    begin
        pseudo_sum_next = {3'b000, src_addr_reg[ADDR_W-1:WORD_W]}
                        + {3'b000, src_addr_reg[WORD_W-1:0]}
                        + {3'b000, dst_addr_reg[ADDR_W-1:WORD_W]}
                        + {3'b000, dst_addr_reg[WORD_W-1:0]}
                        + {{(PSUM_W-PROTO_W){1'b0}}, protocol_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pseudo_sum_reg <= '0;
        else
            pseudo_sum_reg <= pseudo_sum_next;
    end

    assign cfg.use_pseudo = use_pseudo_reg;
    assign cfg.pseudo_sum = pseudo_sum_reg;

endmodule

`default_nettype wire

/* rtl/core/internet_checksum_pseudo_header.sv */
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    data_word, single_byte, last_word
// out      source     out_valid / out_stall  checksum
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat per cycle in while in_stall is low; the accumulator is a single
// 16-bit end-around adder. Input register, accumulate stage, output register:
// each payload passes through them in turn. Stages with room keep accepting
// while out is stalled. rst_n clears valids, sum and count; cfg is always ready.
`default_nettype none

module internet_checksum_pseudo_header
    import ics_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [WORD_W-1:0]     data_word,
    input  wire logic                  single_byte,
    input  wire logic                  last_word,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [WORD_W-1:0]          checksum,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

`include "internet_checksum_pseudo_header_defines.svh"

    ics_cfg_t cfg;

    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_single_reg;
    logic              in_last_reg;

    logic [WORD_W-1:0] sum_reg;
    logic [WORD_W-1:0] sum_next;
    logic [WORD_W-1:0] count_reg;
    logic [WORD_W-1:0] count_next;

    logic              fin_valid_reg;
    logic [WORD_W-1:0] fin_sum_reg;
    logic [WORD_W-1:0] fin_count_reg;

    logic              out_valid_reg;
    logic [WORD_W-1:0] checksum_reg;
    logic [WORD_W-1:0] checksum_next;
    logic [TOTAL_W-1:0] total;

    logic out_load;
    logic fin_free;
    logic acc_move;
    logic in_free;

    ics_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // flow control: a stage moves when the next one has room; the accumulator also moves on a non-last beat
    assign out_load = !out_valid_reg || !out_stall;
    assign fin_free = !fin_valid_reg || out_load;
    assign acc_move = in_valid_reg && (fin_free || !in_last_reg);
    assign in_free  = !in_valid_reg || acc_move;
    assign in_stall = !in_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_free)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_free && in_valid)
        begin
            in_word_reg   <= single_byte ? {data_word[WORD_W-1:8], 8'h00} : data_word;
            in_single_reg <= single_byte;
            in_last_reg   <= last_word;
        end
    end

    always_comb
    begin
        sum_next   = oc_add(sum_reg, in_word_reg);
        count_next = count_reg + (in_single_reg ? 16'd1 : 16'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (acc_move)
        begin
            sum_reg   <= in_last_reg ? '0 : sum_next;
            count_reg <= in_last_reg ? '0 : count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (fin_free)
            fin_valid_reg <= acc_move && in_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (acc_move && in_last_reg)
        begin
            fin_sum_reg   <= sum_next;
            fin_count_reg <= count_next;
        end
    end

    // wide integer sum, then full fold; the fold is zero only when every summed term was zero
    always_comb
    begin
        total = {3'b000, fin_sum_reg};
        if (cfg.use_pseudo)
            total = total + cfg.pseudo_sum + {3'b000, fin_count_reg};
        checksum_next = ~fold(total);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= fin_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && fin_valid_reg)
            checksum_reg <= checksum_next;
    end

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;

    `ICS_ASSERT_NEXT(a_restart_after_last, acc_move && in_last_reg, sum_reg == '0 && count_reg == '0)
    `ICS_ASSERT_NOW(a_stall_means_full, in_stall, in_valid_reg && in_last_reg && fin_valid_reg)
    `ICS_ASSERT_NEXT(a_fin_holds, fin_valid_reg && !out_load, fin_valid_reg && $stable(fin_sum_reg))
    `ICS_ASSERT_NEXT(a_out_loads_from_fin, out_load && fin_valid_reg, out_valid_reg)

endmodule

`default_nettype wire

/* tb/internet_checksum_pseudo_header_checker.sv */
module internet_checksum_pseudo_header_checker
    import ics_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [WORD_W-1:0]     data_word,
    input  logic                  single_byte,
    input  logic                  last_word,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [WORD_W-1:0]     checksum,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    mismatches
);

    logic               hdr_enable    = 1'b0;
    logic [ADDR_W-1:0]  hdr_src       = '0;
    logic [ADDR_W-1:0]  hdr_dst       = '0;
    logic [PROTO_W-1:0] hdr_proto     = '0;
    logic [WORD_W-1:0]  payload_sum   = '0;
    logic [WORD_W-1:0]  payload_bytes = '0;
    logic [WORD_W-1:0]  expected_checksums[$];
    int                 fail_count    = 0;

    initial pending = 0;
    initial mismatches = 0;

    // end-around-carry add, result kept in 16 bits
    function automatic logic [WORD_W-1:0] ones_sum(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        return wide[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, wide[WORD_W]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] total;
        logic [WORD_W-1:0] want;
        if (!rst_n)
        begin
            hdr_enable    = 1'b0;
            hdr_src       = '0;
            hdr_dst       = '0;
            hdr_proto     = '0;
            payload_sum   = '0;
            payload_bytes = '0;
            expected_checksums.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_USE_PSEUDO: hdr_enable = cfg_data[0];
                    REG_SRC_ADDR:   hdr_src    = cfg_data;
                    REG_DST_ADDR:   hdr_dst    = cfg_data;
                    REG_PROTOCOL:   hdr_proto  = cfg_data[PROTO_W-1:0];
                    default:        ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (expected_checksums.size() == 0)
                begin
                    $error("checksum: unexpected beat, actual %h", checksum);
                    fail_count++;
                end
                else
                begin
                    want = expected_checksums.pop_front();
                    if (checksum !== want)
                    begin
                        $error("checksum: expected %h, actual %h", want, checksum);
                        fail_count++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                word = single_byte ? {data_word[15:8], 8'h00} : data_word;
                payload_sum = ones_sum(payload_sum, word);
                payload_bytes = payload_bytes + (single_byte ? 16'd1 : 16'd2);
                if (last_word)
                begin
                    total = payload_sum;
                    if (hdr_enable)
                    begin
                        total = ones_sum(total, hdr_src[31:16]);
                        total = ones_sum(total, hdr_src[15:0]);
                        total = ones_sum(total, hdr_dst[31:16]);
                        total = ones_sum(total, hdr_dst[15:0]);
                        total = ones_sum(total, {8'h00, hdr_proto});
                        total = ones_sum(total, payload_bytes);
                    end
                    expected_checksums.push_back(~total);
                    payload_sum   = '0;
                    payload_bytes = '0;
                end
            end
        end
        pending    <= expected_checksums.size();
        mismatches <= fail_count;
    end

endmodule

/* tb/internet_checksum_pseudo_header_tb.sv */
module internet_checksum_pseudo_header_tb;
    import ics_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [WORD_W-1:0]     data_word   = '0;
    logic                  single_byte = 1'b0;
    logic                  last_word   = 1'b0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [WORD_W-1:0]     checksum;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int pending;
    int mismatches;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int quiet_cycles  = 0;

    internet_checksum_pseudo_header dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_word(data_word),
        .single_byte(single_byte),
        .last_word(last_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .checksum(checksum),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    internet_checksum_pseudo_header_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_word(data_word),
        .single_byte(single_byte),
        .last_word(last_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .checksum(checksum),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pending(pending),
        .mismatches(mismatches)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("internet_checksum_pseudo_header test failed");
            $finish;
        end
    end

    // sink side; a hold request stalls the output for a long stretch
    initial
    begin : receiver
        int hold_seen;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_beat(input logic [WORD_W-1:0] word, input logic one_byte,
                             input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_word   <= word;
        single_byte <= one_byte;
        last_word   <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] use_val,
                              input logic [CFG_DATA_W-1:0] src,
                              input logic [CFG_DATA_W-1:0] dst,
                              input logic [CFG_DATA_W-1:0] proto);
        write_reg(REG_USE_PSEUDO, use_val);
        write_reg(REG_SRC_ADDR, src);
        write_reg(REG_DST_ADDR, dst);
        write_reg(REG_PROTOCOL, proto);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_address();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_payloads(input int beats);
        int                sent;
        int                len;
        int                k;
        logic [WORD_W-1:0] w;
        sent = 0;
        while (sent < beats)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            for (k = 0; k < len; k++)
            begin
                case ($urandom_range(7))
                    0:       w = '0;
                    1:       w = '1;
                    default: w = WORD_W'($urandom());
                endcase
                if (k == len - 1)
                    send_beat(w, 1'($urandom_range(1)), 1'b1);
                else
                    send_beat(w, $urandom_range(19) == 0, 1'b0);
            end
            sent += len;
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int chunk;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain sum straight out of reset
        send_beat(16'h0000, 1'b0, 1'b1);
        send_beat(16'hFFFF, 1'b0, 1'b1);
        send_beat(16'hABCD, 1'b1, 1'b1);
        send_beat(16'hFFFF, 1'b0, 1'b0);
        send_beat(16'h0001, 1'b0, 1'b1);
        // odd byte in the middle of a payload
        send_beat(16'h12FF, 1'b1, 1'b0);
        send_beat(16'h3456, 1'b0, 1'b1);
        settle();

        write_reg(REG_UNUSED, '1);
        set_config('1, '1, '1, '1);
        send_beat(16'hFFFF, 1'b0, 1'b0);
        send_beat(16'h8001, 1'b0, 1'b0);
        send_beat(16'h00FF, 1'b1, 1'b1);
        settle();

        set_config(32'h0000_0001, '0, '0, '0);
        send_beat(16'h0000, 1'b0, 1'b1);
        send_beat(16'hFFFF, 1'b1, 1'b1);
        // header change lands between words of one payload
        send_beat(16'h1234, 1'b0, 1'b0);
        send_beat(16'hFFFF, 1'b0, 1'b0);
        settle();
        set_config(32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0A00_0002, 32'h0000_0011);
        send_beat(16'h0F0F, 1'b0, 1'b1);
        settle();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 85; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 85; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            for (chunk = 0; chunk < 3; chunk++)
            begin
                set_config($urandom(), pick_address(), pick_address(), $urandom());
                if (phase == 0 && chunk == 0)
                    hold_requests <= hold_requests + 1;
                send_payloads(60);
                settle();
            end
        end

        stall_pct = 0;
        settle();
        if (mismatches == 0)
            $display("internet_checksum_pseudo_header test passed");
        else
            $display("internet_checksum_pseudo_header test failed");
        $finish;
    end

endmodule
